[rtl/twirl_coordinate_remap_unit_defines.svh]
// assertion macros for the twirl coordinate remap checker
// no dependencies; included by tcr_checker.sv
`ifndef TWIRL_COORDINATE_REMAP_UNIT_DEFINES_SVH
`define TWIRL_COORDINATE_REMAP_UNIT_DEFINES_SVH

// implication checked in the same cycle, off during reset
`define TCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle, off during reset
`define TCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the following cycle, also across reset
`define TCR_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tcr_pkg.sv]
// shared constants and tables of the twirl coordinate remap unit
// no dependencies; used by all rtl modules
`timescale 1ns / 1ps

package tcr_pkg;

    localparam int GUARD        = 10;
    localparam int GAIN_Q       = 24;
    localparam int CORDIC_ITERS = 24;
    localparam int ZC_W         = 32;
    localparam int Z_W          = 36;
    localparam int ANGLE_W      = 17;
    localparam int INV_W        = 24;
    localparam int T_W          = 17;
    localparam int CFG_DATA_W   = 24;
    localparam int UNIT         = 65536;
    localparam int ROUND_SHIFT  = GUARD + GAIN_Q;

    localparam longint ANG_PI      = 64'sd843314857;
    localparam longint ANG_HALF_PI = 64'sd421657428;
    localparam longint ANG_TWO_PI  = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd10188014;

    localparam logic signed [ANGLE_W-1:0] ANGLE_RESET = 17'sd12288;

    typedef enum logic [1:0] {
        CFG_CENTRE_X    = 2'd0,
        CFG_CENTRE_Y    = 2'd1,
        CFG_INV_RADIUS  = 2'd2,
        CFG_TWIRL_ANGLE = 2'd3
    } cfg_index_t;

    // arctangent of 2^-i, q.28
    function automatic logic [ZC_W-1:0] atan_q28(input logic [4:0] idx);
        logic [ZC_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd210828714;
            5'd1:  v = 32'd124459457;
            5'd2:  v = 32'd65760959;
            5'd3:  v = 32'd33381290;
            5'd4:  v = 32'd16755422;
            5'd5:  v = 32'd8385879;
            5'd6:  v = 32'd4193963;
            5'd7:  v = 32'd2097109;
            5'd8:  v = 32'd1048571;
            5'd9:  v = 32'd524287;
            5'd10: v = 32'd262144;
            5'd11: v = 32'd131072;
            5'd12: v = 32'd65536;
            5'd13: v = 32'd32768;
            5'd14: v = 32'd16384;
            5'd15: v = 32'd8192;
            5'd16: v = 32'd4096;
            5'd17: v = 32'd2048;
            5'd18: v = 32'd1024;
            5'd19: v = 32'd512;
            5'd20: v = 32'd256;
            5'd21: v = 32'd128;
            5'd22: v = 32'd64;
            5'd23: v = 32'd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/tcr_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on tcr_pkg; carries a payload alongside each item
`timescale 1ns / 1ps

module tcr_isqrt
    import tcr_pkg::*;
#(
    parameter int R_W   = 18,
    parameter int PAY_W = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_i,
    input  logic [2*R_W-1:0]    val_i,
    input  logic [PAY_W-1:0]    pay_i,
    output logic                vld_o,
    output logic [R_W-1:0]      root_o,
    output logic [PAY_W-1:0]    pay_o
);

    localparam int SQ_W = 2 * R_W;

    logic [SQ_W-1:0]  rem_reg [R_W];
    logic [SQ_W-1:0]  res_reg [R_W];
    logic [PAY_W-1:0] pay_reg [R_W];
    logic [R_W-1:0]   vld_reg;

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0]  rem_in;
        logic [SQ_W-1:0]  res_in;
        logic [PAY_W-1:0] pay_in;
        logic             vld_in;
        logic [SQ_W-1:0]  trial;
        logic [SQ_W-1:0]  rem_next;
        logic [SQ_W-1:0]  res_next;

        if (k == 0) begin : g_first
            assign rem_in = val_i;
            assign res_in = '0;
            assign pay_in = pay_i;
            assign vld_in = vld_i;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign pay_in = pay_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign vld_o  = vld_reg[R_W-1];
    assign root_o = res_reg[R_W-1][R_W-1:0];
    assign pay_o  = pay_reg[R_W-1];

endmodule

[rtl/tcr_cordic.sv]
// pipelined rotation-mode cordic, one iteration per stage
// depends on tcr_pkg for the arctangent table
`timescale 1ns / 1ps

module tcr_cordic
    import tcr_pkg::*;
#(
    parameter int X_W = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   vld_i,
    input  logic signed [X_W-1:0]  x_i,
    input  logic signed [X_W-1:0]  y_i,
    input  logic signed [ZC_W-1:0] z_i,
    input  logic                   neg_i,
    output logic                   vld_o,
    output logic signed [X_W-1:0]  x_o,
    output logic signed [X_W-1:0]  y_o,
    output logic                   neg_o
);

    logic signed [X_W-1:0]  x_reg [CORDIC_ITERS];
    logic signed [X_W-1:0]  y_reg [CORDIC_ITERS];
    logic signed [ZC_W-1:0] z_reg [CORDIC_ITERS];
    logic [CORDIC_ITERS-1:0] neg_reg;
    logic [CORDIC_ITERS-1:0] vld_reg;

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        logic signed [X_W-1:0]  x_in;
        logic signed [X_W-1:0]  y_in;
        logic signed [ZC_W-1:0] z_in;
        logic                   neg_in;
        logic                   vld_in;
        logic signed [X_W-1:0]  xs;
        logic signed [X_W-1:0]  ys;
        logic signed [ZC_W-1:0] ang;

        if (k == 0) begin : g_first
            assign x_in   = x_i;
            assign y_in   = y_i;
            assign z_in   = z_i;
            assign neg_in = neg_i;
            assign vld_in = vld_i;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign xs  = x_in >>> k;
        assign ys  = y_in >>> k;
        assign ang = $signed(atan_q28(5'(k)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                neg_reg[k] <= neg_in;
                if (z_in >= 0) begin
                    x_reg[k] <= x_in - ys;
                    y_reg[k] <= y_in + xs;
                    z_reg[k] <= z_in - ang;
                end else begin
                    x_reg[k] <= x_in + ys;
                    y_reg[k] <= y_in - xs;
                    z_reg[k] <= z_in + ang;
                end
            end
        end
    end

    assign vld_o = vld_reg[CORDIC_ITERS-1];
    assign x_o   = x_reg[CORDIC_ITERS-1];
    assign y_o   = y_reg[CORDIC_ITERS-1];
    assign neg_o = neg_reg[CORDIC_ITERS-1];

endmodule

[rtl/twirl_coordinate_remap_unit.sv]
// twirl coordinate remap unit: top level of the pipeline
// depends on tcr_pkg, tcr_isqrt and tcr_cordic
//
// usage:
//   s_ channel takes one output pixel coordinate per item (pixel_x, pixel_y)
//   m_ channel returns the twirled source coordinate (source_x, source_y) in
//   sixteenths of a pixel, rounded and saturated, one item per input item
//   cfg channel writes centre_x, centre_y, inv_radius and twirl_angle by index;
//   it is always ready and should be written only while the pipeline is empty
// timing:
//   latency is COORD_BITS + FRAC_BITS + 41 cycles (58 at the defaults): three
//   offset/square stages, one square-root stage per result bit, nine falloff and
//   angle-reduction stages, 24 cordic stages, and four stages of sign, gain,
//   rounding and saturation
//   throughput is one item per cycle; every stage is a register
// reset and stall:
//   aresetn clears all valid bits and loads the register reset values
//   (twirl_angle 3.0 rad, others zero)
//   when m_tready is low with a result pending the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated
`timescale 1ns / 1ps

module twirl_coordinate_remap_unit
    import tcr_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata, // pixel_x, pixel_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((2*(COORD_BITS+FRAC_BITS+2)+7)/8)*8-1:0] m_tdata, // source_x, source_y
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_BITS = COORD_BITS + FRAC_BITS;
    localparam int OUT_BITS = POS_BITS + 2;
    localparam int OUT_W    = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam int D_W      = POS_BITS + 1;
    localparam int SQ_W     = 2 * D_W;
    localparam int UR_W     = D_W + INV_W;
    localparam int X_W      = D_W + GUARD + 3;
    localparam int P_W      = X_W + GAIN_Q + 1;
    localparam int S_W      = P_W + 1;
    localparam int V_W      = S_W - ROUND_SHIFT;
    localparam int HALF     = 1 << (FRAC_BITS - 1);

    localparam logic signed [Z_W-1:0] Z_PI      = Z_W'(ANG_PI);
    localparam logic signed [Z_W-1:0] Z_TWO_PI  = Z_W'(ANG_TWO_PI);
    localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(ANG_HALF_PI);
    localparam logic signed [V_W-1:0] SAT_LO    = -(V_W'(1) <<< POS_BITS);
    localparam logic signed [V_W-1:0] SAT_HI    = (V_W'(1) <<< (POS_BITS + 1)) - V_W'(1);

    // configuration registers
    logic [POS_BITS-1:0]       centre_x_reg;
    logic [POS_BITS-1:0]       centre_y_reg;
    logic [INV_W-1:0]          inv_radius_reg;
    logic signed [ANGLE_W-1:0] twirl_angle_reg;
    cfg_index_t                cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_index_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg    <= '0;
            centre_y_reg    <= '0;
            inv_radius_reg  <= '0;
            twirl_angle_reg <= ANGLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_sel)
                CFG_CENTRE_X:    centre_x_reg    <= cfg_data[POS_BITS-1:0];
                CFG_CENTRE_Y:    centre_y_reg    <= cfg_data[POS_BITS-1:0];
                CFG_INV_RADIUS:  inv_radius_reg  <= cfg_data[INV_W-1:0];
                CFG_TWIRL_ANGLE: twirl_angle_reg <= $signed(cfg_data[ANGLE_W-1:0]);
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // offset and squares
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic signed [D_W-1:0] dx_next;
    logic signed [D_W-1:0] dy_next;
    logic signed [D_W-1:0] dx_reg;
    logic signed [D_W-1:0] dy_reg;
    logic signed [SQ_W-1:0] sqx_reg;
    logic signed [SQ_W-1:0] sqy_reg;
    logic signed [D_W-1:0] dx2_reg;
    logic signed [D_W-1:0] dy2_reg;
    logic [SQ_W-1:0]       sum_reg;
    logic signed [D_W-1:0] dx3_reg;
    logic signed [D_W-1:0] dy3_reg;
    logic [2:0]            pre_vld_reg;

    assign px = s_tdata[COORD_BITS-1:0];
    assign py = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign dx_next = $signed({1'b0, px, {FRAC_BITS{1'b0}}}) + D_W'(HALF)
                     - $signed({1'b0, centre_x_reg});
    assign dy_next = $signed({1'b0, py, {FRAC_BITS{1'b0}}}) + D_W'(HALF)
                     - $signed({1'b0, centre_y_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg <= '0;
        end else if (en) begin
            pre_vld_reg <= {pre_vld_reg[1:0], s_tvalid};
        end
        if (en) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            sum_reg <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
        end
    end

    // radius
    logic                 rt_vld;
    logic [D_W-1:0]       root;
    logic [2*D_W-1:0]     rt_pay;

    tcr_isqrt #(
        .R_W   (D_W),
        .PAY_W (2 * D_W)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (pre_vld_reg[2]),
        .val_i   (sum_reg),
        .pay_i   ({dy3_reg, dx3_reg}),
        .vld_o   (rt_vld),
        .root_o  (root),
        .pay_o   (rt_pay)
    );

    // falloff, angle and range reduction
    logic [UR_W-1:0]          ur_reg;
    logic [UR_W-1:0]          u_full;
    logic [T_W-1:0]           t_next;
    logic [T_W-1:0]           t_reg;
    logic [2*T_W-1:0]         tt_reg;
    logic signed [Z_W-1:0]    pa_reg;
    logic signed [Z_W-1:0]    pa_rnd;
    logic signed [Z_W-1:0]    z_reg [4];
    logic signed [Z_W-1:0]    z_fold;
    logic                     neg_next;
    logic                     neg_reg;
    logic signed [ZC_W-1:0]   zc_reg;
    logic [2*D_W-1:0]         dly_reg [8];
    logic signed [D_W-1:0]    dxa;
    logic signed [D_W-1:0]    dya;
    logic signed [X_W-1:0]    x0_reg;
    logic signed [X_W-1:0]    y0_reg;
    logic [8:0]               ang_vld_reg;

    assign u_full = ur_reg >> (FRAC_BITS + 8);
    assign t_next = (u_full > UR_W'(UNIT)) ? '0 : T_W'(UR_W'(UNIT) - u_full);
    assign pa_rnd = pa_reg + Z_W'(32768);
    assign dxa    = $signed(dly_reg[7][D_W-1:0]);
    assign dya    = $signed(dly_reg[7][2*D_W-1:D_W]);

    always_comb begin
        neg_next = 1'b0;
        z_fold   = z_reg[3];
        if (z_reg[3] > Z_HALF_PI) begin
            z_fold   = z_reg[3] - Z_PI;
            neg_next = 1'b1;
        end else if (z_reg[3] < -Z_HALF_PI) begin
            z_fold   = z_reg[3] + Z_PI;
            neg_next = 1'b1;
        end
    end

    for (genvar k = 1; k < 4; k++) begin : g_reduce
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[k-1] > Z_PI) begin
                    z_reg[k] <= z_reg[k-1] - Z_TWO_PI;
                end else if (z_reg[k-1] < -Z_PI) begin
                    z_reg[k] <= z_reg[k-1] + Z_TWO_PI;
                end else begin
                    z_reg[k] <= z_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 1; k < 8; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (en) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_vld_reg <= '0;
        end else if (en) begin
            ang_vld_reg <= {ang_vld_reg[7:0], rt_vld};
        end
        if (en) begin
            ur_reg     <= UR_W'(root) * UR_W'(inv_radius_reg);
            dly_reg[0] <= rt_pay;
            t_reg      <= t_next;
            tt_reg     <= t_reg * t_reg;
            pa_reg     <= twirl_angle_reg * $signed({1'b0, tt_reg[2*T_W-1:16]});
            z_reg[0]   <= $signed({pa_rnd[Z_W-1:16], 16'd0});
            neg_reg    <= neg_next;
            zc_reg     <= ZC_W'(z_fold);
            x0_reg     <= {{(X_W-D_W-GUARD){dxa[D_W-1]}}, dxa, {GUARD{1'b0}}};
            y0_reg     <= {{(X_W-D_W-GUARD){dya[D_W-1]}}, dya, {GUARD{1'b0}}};
        end
    end

    // rotation
    logic                  cr_vld;
    logic signed [X_W-1:0] cr_x;
    logic signed [X_W-1:0] cr_y;
    logic                  cr_neg;

    tcr_cordic #(
        .X_W (X_W)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (ang_vld_reg[8]),
        .x_i     (x0_reg),
        .y_i     (y0_reg),
        .z_i     (zc_reg),
        .neg_i   (neg_reg),
        .vld_o   (cr_vld),
        .x_o     (cr_x),
        .y_o     (cr_y),
        .neg_o   (cr_neg)
    );

    // sign, gain, rounding and saturation
    logic signed [X_W-1:0]        xn_reg;
    logic signed [X_W-1:0]        yn_reg;
    logic signed [P_W-1:0]        mx_reg;
    logic signed [P_W-1:0]        my_reg;
    logic signed [S_W-1:0]        cx_term;
    logic signed [S_W-1:0]        cy_term;
    logic signed [S_W-1:0]        sx;
    logic signed [S_W-1:0]        sy;
    logic signed [V_W-1:0]        vx_reg;
    logic signed [V_W-1:0]        vy_reg;
    logic signed [OUT_BITS-1:0]   ox;
    logic signed [OUT_BITS-1:0]   oy;
    logic [2:0]                   post_vld_reg;
    logic [OUT_W-1:0]             m_tdata_reg;

    assign cx_term = (S_W'($signed({1'b0, centre_x_reg})) - S_W'(HALF)) <<< ROUND_SHIFT;
    assign cy_term = (S_W'($signed({1'b0, centre_y_reg})) - S_W'(HALF)) <<< ROUND_SHIFT;
    assign sx = (S_W'(mx_reg) + cx_term + (S_W'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    assign sy = (S_W'(my_reg) + cy_term + (S_W'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

    always_comb begin
        priority if (vx_reg < SAT_LO) begin
            ox = OUT_BITS'(SAT_LO);
        end else if (vx_reg > SAT_HI) begin
            ox = OUT_BITS'(SAT_HI);
        end else begin
            ox = OUT_BITS'(vx_reg);
        end
        priority if (vy_reg < SAT_LO) begin
            oy = OUT_BITS'(SAT_LO);
        end else if (vy_reg > SAT_HI) begin
            oy = OUT_BITS'(SAT_HI);
        end else begin
            oy = OUT_BITS'(vy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            post_vld_reg <= {post_vld_reg[1:0], cr_vld};
            m_tvalid_reg <= post_vld_reg[2];
        end
        if (en) begin
            xn_reg      <= cr_neg ? -cr_x : cr_x;
            yn_reg      <= cr_neg ? -cr_y : cr_y;
            mx_reg      <= xn_reg * $signed({1'b0, GAIN_Q'(CORDIC_GAIN)});
            my_reg      <= yn_reg * $signed({1'b0, GAIN_Q'(CORDIC_GAIN)});
            vx_reg      <= V_W'(sx);
            vy_reg      <= V_W'(sy);
            m_tdata_reg <= OUT_W'({oy, ox});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/tcr_checker.sv]
// port-level checker for the twirl coordinate remap unit, with its bind
// depends on twirl_coordinate_remap_unit_defines.svh and tcr_pkg
`timescale 1ns / 1ps
`include "twirl_coordinate_remap_unit_defines.svh"

module tcr_checker
    import tcr_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 4
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata, // pixel_x, pixel_y
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [((2*(COORD_BITS+FRAC_BITS+2)+7)/8)*8-1:0] m_tdata, // source_x, source_y
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [1:0]            cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    `TCR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")
    `TCR_ASSERT_NOW(a_in_open, !m_tvalid, s_tready, "input blocked with an empty output register")
    `TCR_ASSERT_NOW(a_in_stall, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `TCR_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "result item present after reset")
    `TCR_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind twirl_coordinate_remap_unit tcr_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_tcr_checker (.*);
